[hdl/ufcc_pkg.sv]
// shared constants, types and register codes for the union-find cost engine
package ufcc_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int RANK_W    = 4;
  localparam int COST_W    = 16;
  localparam int TOTAL_W   = 26;
  localparam int PROD_W    = NODE_W + COST_W;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SITE_COST  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINK_COST  = 2'd2;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [NODE_W-1:0] parent;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              start;
    logic [NODE_W-1:0] node_count;
    logic [NODE_W-1:0] merges;
    logic [COST_W-1:0] site_cost;
    logic [COST_W-1:0] link_cost;
  } cost_req_t;

  typedef struct packed {
    logic               done;
    logic [NODE_W-1:0]  comps;
    logic [TOTAL_W-1:0] total_cost;
  } cost_rsp_t;

endpackage

[hdl/ufcc_if.sv]
// edge and result channel interfaces
interface ufcc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [ufcc_pkg::NODE_W-1:0] node_a;
  logic [ufcc_pkg::NODE_W-1:0] node_b;

  modport source (output valid, output opcode, output node_a, output node_b, input ready);
  modport sink   (input valid, input opcode, input node_a, input node_b, output ready);
endinterface

interface ufcc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         merged;
  logic [ufcc_pkg::NODE_W-1:0]  component_count;
  logic [ufcc_pkg::TOTAL_W-1:0] total_cost;

  modport source (output valid, output merged, output component_count, output total_cost,
                  input ready);
  modport sink   (input valid, input merged, input component_count, input total_cost,
                  output ready);
endinterface

[hdl/ufcc_ram.sv]
// generic single-write, single-read ram with registered read data
module ufcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/ufcc_cost.sv]
// component count and cost evaluation on one shared multiplier
module ufcc_cost (
  input  logic                clk,
  input  logic                rst_n,
  input  ufcc_pkg::cost_req_t req,
  output ufcc_pkg::cost_rsp_t rsp
);
  import ufcc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALL   = 3'd1;
  localparam logic [2:0] ST_LINK  = 3'd2;
  localparam logic [2:0] ST_SITE  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;

  logic [2:0]         step_r, step_nxt;
  logic               done_r;
  logic [NODE_W-1:0]  comps;
  logic [NODE_W-1:0]  comps_r;
  logic [NODE_W-1:0]  mul_a;
  logic [COST_W-1:0]  mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  all_r, lnk_r, cmp_r;
  logic [PROD_W:0]    mixed;
  logic [TOTAL_W-1:0] cost_r;

  // merges past node count saturate the component count at zero
  assign comps = (req.merges >= req.node_count) ? '0 : req.node_count - req.merges;

  always_comb begin
    unique case (step_r)
      ST_LINK: begin
        mul_a = req.merges;
        mul_b = req.link_cost;
      end
      ST_SITE: begin
        mul_a = comps;
        mul_b = req.site_cost;
      end
      default: begin
        mul_a = req.node_count;
        mul_b = req.site_cost;
      end
    endcase
  end

  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign mixed = {1'b0, lnk_r} + {1'b0, cmp_r};

  always_comb begin
    step_nxt = step_r;
    unique case (step_r)
      ST_IDLE: if (req.start) step_nxt = ST_ALL;
      ST_ALL:  step_nxt = ST_LINK;
      ST_LINK: step_nxt = ST_SITE;
      ST_SITE: step_nxt = ST_SUM;
      ST_SUM:  step_nxt = ST_IDLE;
      default: step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= (step_r == ST_SUM);
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == ST_ALL)  all_r <= prod;
    if (step_r == ST_LINK) lnk_r <= prod;
    if (step_r == ST_SITE) cmp_r <= prod;
    if (step_r == ST_SUM) begin
      comps_r <= comps;
      cost_r  <= (mixed < {1'b0, all_r}) ? mixed[TOTAL_W-1:0] : all_r[TOTAL_W-1:0];
    end
  end

  assign rsp.done       = done_r;
  assign rsp.comps      = comps_r;
  assign rsp.total_cost = cost_r;

endmodule

[hdl/union_find_component_cost.sv]
// union-find by rank engine reporting component count and connection cost
// root walk: one ram read per parent link step; depth stays below 11 under union by rank
// flow: one word at a time; a finish word adds a store clear after its result
// reset: synchronous active-low rst_n, then a clearing pass of the parent/rank ram
//   during which no word is accepted; config writes are taken at all times
module union_find_component_cost (
  input  logic                                clk,
  input  logic                                rst_n,
  ufcc_in_if.sink                             in_ch,
  ufcc_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ufcc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ufcc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ufcc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import ufcc_pkg::*;

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_BUMP  = 3'd4;
  localparam logic [2:0] S_COST  = 3'd5;
  localparam logic [2:0] S_WAIT  = 3'd6;
  localparam logic [2:0] S_SEND  = 3'd7;

  // config registers
  logic [NODE_W-1:0] node_count_r;
  logic [COST_W-1:0] site_cost_r;
  logic [COST_W-1:0] link_cost_r;
  logic              cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  // sequencer
  logic [2:0]        state_r, state_nxt;
  logic [NODE_W-1:0] clr_r;
  logic              op_r;
  logic [NODE_W-1:0] b_r;
  logic [NODE_W-1:0] cur_r;
  logic              side_r;
  logic [NODE_W-1:0] x_r, y_r;
  logic [RANK_W-1:0] xrank_r, yrank_r;
  logic              merged_r;
  logic [NODE_W-1:0] merge_cnt_r;

  // output register
  logic               out_valid_r;
  logic               out_merged_r;
  logic [NODE_W-1:0]  out_comps_r;
  logic [TOTAL_W-1:0] out_cost_r;
  logic               out_free;

  // ram access
  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_ent;
  logic              at_root;

  logic              accept;
  logic              edge_ok;

  cost_req_t         creq;
  cost_rsp_t         crsp;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_W'(1);
      site_cost_r  <= '0;
      link_cost_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NODE_COUNT: node_count_r <= pwdata[NODE_W-1:0];
        REG_SITE_COST:  site_cost_r  <= pwdata[COST_W-1:0];
        REG_LINK_COST:  link_cost_r  <= pwdata[COST_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NODE_COUNT: prdata = CFG_DATA_W'(node_count_r);
      REG_SITE_COST:  prdata = CFG_DATA_W'(site_cost_r);
      REG_LINK_COST:  prdata = CFG_DATA_W'(link_cost_r);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input side
  // a word is taken whenever the sequencer is idle; the output register decouples
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // endpoints must be in 1..node_count; anything else is a no-op edge
  assign edge_ok = (in_ch.opcode == OP_EDGE)
                && (in_ch.node_a != '0) && (in_ch.node_a <= node_count_r)
                && (in_ch.node_b != '0) && (in_ch.node_b <= node_count_r);

  // ---------------------------------------------------------------- parent/rank store
  assign rd_ent  = entry_t'(ram_rdata);
  assign at_root = (rd_ent.parent == cur_r);

  // read address runs one step ahead: each parent read is issued as soon as the previous entry arrives
  always_comb begin
    unique case (state_r)
      S_IDLE:  ram_raddr = in_ch.node_a;
      S_FIND:  ram_raddr = !at_root ? rd_ent.parent : b_r;
      default: ram_raddr = cur_r;
    endcase
  end

  // write port: clearing pass, hang one root below the other, bump rank
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_r;
    ram_wdata = '{rank: '0, parent: clr_r};
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_LINK: begin
        ram_we = (x_r != y_r);
        if (xrank_r > yrank_r) begin
          ram_waddr = y_r;
          ram_wdata = '{rank: yrank_r, parent: x_r};
        end else begin
          ram_waddr = x_r;
          ram_wdata = '{rank: xrank_r, parent: y_r};
        end
      end
      S_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = y_r;
        ram_wdata = '{rank: yrank_r + RANK_W'(1), parent: y_r};
      end
      default: ;
    endcase
  end

  ufcc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NODES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------- cost unit
  assign creq.start      = (state_r == S_COST);
  assign creq.node_count = node_count_r;
  assign creq.merges     = merge_cnt_r;
  assign creq.site_cost  = site_cost_r;
  assign creq.link_cost  = link_cost_r;

  ufcc_cost u_cost (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == NODE_W'(MAX_NODES - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = edge_ok ? S_FIND : S_COST;
      S_FIND:  if (at_root && side_r) state_nxt = S_LINK;
      S_LINK: begin
        // equal ranks grow the surviving root unless already saturated
        if ((x_r != y_r) && (xrank_r == yrank_r) && (yrank_r != RANK_MAX)) begin
          state_nxt = S_BUMP;
        end else begin
          state_nxt = S_COST;
        end
      end
      S_BUMP:  state_nxt = S_COST;
      S_COST:  state_nxt = S_WAIT;
      S_WAIT:  if (crsp.done) state_nxt = S_SEND;
      S_SEND:  if (out_free) state_nxt = (op_r == OP_FINISH) ? S_CLEAR : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      merge_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_r <= clr_r + NODE_W'(1);
      end
      if (state_r == S_LINK && x_r != y_r) begin
        merge_cnt_r <= merge_cnt_r + NODE_W'(1);
      end
      // finish: result goes out with pre-clear values, then the store is wiped
      if (state_r == S_SEND && out_free && op_r == OP_FINISH) begin
        merge_cnt_r <= '0;
        clr_r       <= '0;
      end
    end
  end

  // datapath registers of the root walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.opcode;
      b_r      <= in_ch.node_b;
      cur_r    <= in_ch.node_a;
      side_r   <= 1'b0;
      merged_r <= 1'b0;
    end
    if (state_r == S_FIND) begin
      if (!at_root) begin
        cur_r <= rd_ent.parent;
      end else if (!side_r) begin
        x_r     <= cur_r;
        xrank_r <= rd_ent.rank;
        cur_r   <= b_r;
        side_r  <= 1'b1;
      end else begin
        y_r     <= cur_r;
        yrank_r <= rd_ent.rank;
      end
    end
    if (state_r == S_LINK) begin
      merged_r <= (x_r != y_r);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_SEND && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SEND && out_free) begin
      out_merged_r <= merged_r;
      out_comps_r  <= crsp.comps;
      out_cost_r   <= crsp.total_cost;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.merged          = out_merged_r;
  assign out_ch.component_count = out_comps_r;
  assign out_ch.total_cost      = out_cost_r;

endmodule
